// ===== rtl/mcme_pkg.sv =====
package mcme_pkg;

    // Field widths. Weights are Q4.12; the fraction width only sets the
    // meaning of the values, and no hardware depends on it.
    localparam int COUNT_BITS  = 24;
    localparam int WEIGHT_BITS = 16;

    // Derived widths of the accumulators and the report engine.
    localparam int SUM_BITS  = COUNT_BITS + WEIGHT_BITS;
    localparam int SQ_BITS   = COUNT_BITS + 2 * WEIGHT_BITS;
    localparam int PROD_BITS = 2 * SUM_BITS;
    localparam int ROOT_BITS = (SQ_BITS + 1) / 2;
    localparam int RAD_BITS  = 2 * ROOT_BITS;
    localparam int REM_BITS  = (COUNT_BITS > ROOT_BITS) ? COUNT_BITS : ROOT_BITS;
    localparam int ITER_BITS = $clog2(PROD_BITS);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_MEAN_LOAD,
        OP_DIV_STEP,
        OP_MUL_LOAD,
        OP_MUL_STEP,
        OP_RAD_LOAD,
        OP_SQRT_STEP,
        OP_ERR_LOAD,
        OP_OUT_LOAD
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   acc_en;
        logic   snap;
    } t_dp_cmd;

endpackage

// ===== rtl/mcme_if.sv =====
interface mcme_in_if;
    logic                          valid;
    logic                          ready;
    logic [mcme_pkg::WEIGHT_BITS-1:0] weight;
    logic                          first;
    logic                          last;

    modport source (output valid, output weight, output first, output last, input ready);
    modport sink   (input valid, input weight, input first, input last, output ready);
endinterface

interface mcme_out_if;
    logic                             valid;
    logic                             ready;
    logic [mcme_pkg::COUNT_BITS-1:0]  event_count;
    logic [mcme_pkg::WEIGHT_BITS-1:0] mean_value;
    logic [mcme_pkg::WEIGHT_BITS-1:0] error_value;
    logic                             count_saturated;

    modport source (output valid, output event_count, output mean_value,
                    output error_value, output count_saturated, input ready);
    modport sink   (input valid, input event_count, input mean_value,
                    input error_value, input count_saturated, output ready);
endinterface

// ===== rtl/mcme_dp.sv =====
module mcme_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  mcme_pkg::t_dp_cmd                i_cmd,
    input  logic [mcme_pkg::WEIGHT_BITS-1:0] i_weight,
    input  logic                             i_first,
    output logic [mcme_pkg::COUNT_BITS-1:0]  o_event_count,
    output logic [mcme_pkg::WEIGHT_BITS-1:0] o_mean_value,
    output logic [mcme_pkg::WEIGHT_BITS-1:0] o_error_value,
    output logic                             o_count_saturated
);
    import mcme_pkg::*;

    // Running accumulators.
    logic [SUM_BITS-1:0]   r_sum, n_sum;
    logic [SQ_BITS-1:0]    r_sq, n_sq;
    logic [COUNT_BITS-1:0] r_cnt, n_cnt;
    logic                  r_sat, n_sat;

    // Snapshot taken with a report request.
    logic [SUM_BITS-1:0]   r_snap_sum;
    logic [SQ_BITS-1:0]    r_snap_sq;
    logic [COUNT_BITS-1:0] r_snap_cnt;
    logic                  r_snap_sat;

    // Shared work registers of the report engine.
    logic [PROD_BITS-1:0]   r_acc;
    logic [REM_BITS-1:0]    r_rem;
    logic [SUM_BITS-1:0]    r_aux;
    logic [WEIGHT_BITS-1:0] r_mean;

    // Output register.
    logic [COUNT_BITS-1:0]  r_o_count;
    logic [WEIGHT_BITS-1:0] r_o_mean;
    logic [WEIGHT_BITS-1:0] r_o_err;
    logic                   r_o_sat;

    logic [SUM_BITS-1:0]      base_sum;
    logic [SQ_BITS-1:0]       base_sq;
    logic [COUNT_BITS-1:0]    base_cnt;
    logic                     cnt_full;
    logic [2*WEIGHT_BITS-1:0] w_sq;

    logic [COUNT_BITS:0]    div_part;
    logic [COUNT_BITS:0]    div_diff;
    logic                   div_ge;
    logic [ROOT_BITS+1:0]   sq_part;
    logic [ROOT_BITS+1:0]   sq_trial;
    logic [ROOT_BITS+1:0]   sq_diff;
    logic                   sq_ge;
    logic [PROD_BITS-1:0]   sq_ext;
    logic                   rad_ok;
    logic [PROD_BITS-1:0]   rad_val;
    logic [PROD_BITS-1:0]   mul_addend;
    logic                   cnt_zero;

    always_comb begin
        base_sum = i_first ? '0 : r_sum;
        base_sq  = i_first ? '0 : r_sq;
        base_cnt = i_first ? '0 : r_cnt;
        cnt_full = (base_cnt == COUNT_MAX);
        w_sq     = i_weight * i_weight;
        n_sum    = cnt_full ? base_sum : base_sum + SUM_BITS'(i_weight);
        n_sq     = cnt_full ? base_sq : base_sq + SQ_BITS'(w_sq);
        n_cnt    = cnt_full ? base_cnt : base_cnt + COUNT_BITS'(1);
        n_sat    = (!i_first && r_sat) || cnt_full;
    end

    // One restoring-division step: quotient bits shift in at the bottom of r_acc.
    always_comb begin
        div_part = {r_rem[COUNT_BITS-1:0], r_acc[PROD_BITS-1]};
        div_diff = div_part - {1'b0, r_snap_cnt};
        div_ge   = (div_part >= {1'b0, r_snap_cnt});
    end

    // One digit-recurrence square root step: two radicand bits per step.
    always_comb begin
        sq_part  = {r_rem[ROOT_BITS-1:0], r_acc[PROD_BITS-1 -: 2]};
        sq_trial = {r_aux[ROOT_BITS-1:0], 2'b01};
        sq_diff  = sq_part - sq_trial;
        sq_ge    = (sq_part >= sq_trial);
    end

    // Radicand: clamp to zero when the squared-sum term exceeds the square sum.
    always_comb begin
        sq_ext  = PROD_BITS'(r_snap_sq);
        rad_ok  = (r_acc <= sq_ext);
        rad_val = rad_ok ? (sq_ext - r_acc) : '0;
        mul_addend = r_aux[SUM_BITS-1] ? PROD_BITS'(r_snap_sum) : '0;
        cnt_zero   = (r_snap_cnt == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_sq  <= '0;
            r_cnt <= '0;
            r_sat <= 1'b0;
        end else if (i_cmd.acc_en) begin
            r_sum <= n_sum;
            r_sq  <= n_sq;
            r_cnt <= n_cnt;
            r_sat <= n_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.snap) begin
            r_snap_sum <= n_sum;
            r_snap_sq  <= n_sq;
            r_snap_cnt <= n_cnt;
            r_snap_sat <= n_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_MEAN_LOAD: begin
                r_acc <= {r_snap_sum, {SUM_BITS{1'b0}}};
                r_rem <= '0;
            end
            OP_DIV_STEP: begin
                r_acc <= {r_acc[PROD_BITS-2:0], div_ge};
                r_rem <= div_ge ? REM_BITS'(div_diff[COUNT_BITS-1:0])
                                : REM_BITS'(div_part[COUNT_BITS-1:0]);
            end
            OP_MUL_LOAD: begin
                // quotient of the mean division is in the low bits of r_acc
                r_mean <= r_acc[WEIGHT_BITS-1:0];
                r_acc  <= '0;
                r_aux  <= r_snap_sum;
                r_rem  <= '0;
            end
            OP_MUL_STEP: begin
                r_acc <= {r_acc[PROD_BITS-2:0], 1'b0} + mul_addend;
                r_aux <= {r_aux[SUM_BITS-2:0], 1'b0};
            end
            OP_RAD_LOAD: begin
                r_acc <= rad_val << (PROD_BITS - RAD_BITS);
                r_rem <= '0;
                r_aux <= '0;
            end
            OP_SQRT_STEP: begin
                r_acc <= {r_acc[PROD_BITS-3:0], 2'b00};
                r_rem <= sq_ge ? REM_BITS'(sq_diff[ROOT_BITS-1:0])
                               : REM_BITS'(sq_part[ROOT_BITS-1:0]);
                r_aux <= SUM_BITS'({r_aux[ROOT_BITS-2:0], sq_ge});
            end
            OP_ERR_LOAD: begin
                r_acc <= PROD_BITS'(r_aux[ROOT_BITS-1:0]) << (PROD_BITS - ROOT_BITS);
                r_rem <= '0;
            end
            OP_OUT_LOAD: begin
                r_o_count <= r_snap_cnt;
                r_o_sat   <= r_snap_sat;
                r_o_mean  <= cnt_zero ? '0 : r_mean;
                r_o_err   <= cnt_zero ? '0 : r_acc[WEIGHT_BITS-1:0];
            end
            default: begin
            end
        endcase
    end

    assign o_event_count     = r_o_count;
    assign o_mean_value      = r_o_mean;
    assign o_error_value     = r_o_err;
    assign o_count_saturated = r_o_sat;

`ifndef SYNTHESIS
    a_sat_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sat |-> (r_cnt == COUNT_MAX))
        else $error("saturation flag set with count below maximum");
`endif

endmodule

// ===== rtl/mcme_ctrl.sv =====
module mcme_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_last,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output mcme_pkg::t_dp_cmd o_cmd
);
    import mcme_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MEAN_LOAD,
        ST_MEAN_DIV,
        ST_MUL_LOAD,
        ST_MUL,
        ST_PROD_DIV,
        ST_RAD,
        ST_SQRT,
        ST_ERR_LOAD,
        ST_ERR_DIV,
        ST_DONE
    } t_state;

    t_state               r_state;
    logic [ITER_BITS-1:0] r_iter;
    logic                 r_out_valid;
    logic                 accept;
    logic                 out_free;
    logic                 iter_done;

    always_comb begin
        // A report request waits while the engine is busy; plain weights never do.
        o_in_ready = (r_state == ST_IDLE) || !i_in_last;
        accept     = i_in_valid && o_in_ready;
        out_free   = !r_out_valid || i_out_ready;
        iter_done  = (r_iter == '0);

        o_cmd.acc_en = accept;
        o_cmd.snap   = accept && i_in_last;
        case (r_state)
            ST_MEAN_LOAD: o_cmd.op = OP_MEAN_LOAD;
            ST_MEAN_DIV:  o_cmd.op = OP_DIV_STEP;
            ST_MUL_LOAD:  o_cmd.op = OP_MUL_LOAD;
            ST_MUL:       o_cmd.op = OP_MUL_STEP;
            ST_PROD_DIV:  o_cmd.op = OP_DIV_STEP;
            ST_RAD:       o_cmd.op = OP_RAD_LOAD;
            ST_SQRT:      o_cmd.op = OP_SQRT_STEP;
            ST_ERR_LOAD:  o_cmd.op = OP_ERR_LOAD;
            ST_ERR_DIV:   o_cmd.op = OP_DIV_STEP;
            ST_DONE:      o_cmd.op = out_free ? OP_OUT_LOAD : OP_NONE;
            default:      o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Raise valid with the output load; drop it on its transfer.
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (o_cmd.snap) begin
                        r_state <= ST_MEAN_LOAD;
                    end
                end
                ST_MEAN_LOAD: begin
                    r_state <= ST_MEAN_DIV;
                    r_iter  <= ITER_BITS'(SUM_BITS - 1);
                end
                ST_MEAN_DIV: begin
                    if (iter_done) begin
                        r_state <= ST_MUL_LOAD;
                    end else begin
                        r_iter <= r_iter - ITER_BITS'(1);
                    end
                end
                ST_MUL_LOAD: begin
                    r_state <= ST_MUL;
                    r_iter  <= ITER_BITS'(SUM_BITS - 1);
                end
                ST_MUL: begin
                    if (iter_done) begin
                        r_state <= ST_PROD_DIV;
                        r_iter  <= ITER_BITS'(PROD_BITS - 1);
                    end else begin
                        r_iter <= r_iter - ITER_BITS'(1);
                    end
                end
                ST_PROD_DIV: begin
                    if (iter_done) begin
                        r_state <= ST_RAD;
                    end else begin
                        r_iter <= r_iter - ITER_BITS'(1);
                    end
                end
                ST_RAD: begin
                    r_state <= ST_SQRT;
                    r_iter  <= ITER_BITS'(ROOT_BITS - 1);
                end
                ST_SQRT: begin
                    if (iter_done) begin
                        r_state <= ST_ERR_LOAD;
                    end else begin
                        r_iter <= r_iter - ITER_BITS'(1);
                    end
                end
                ST_ERR_LOAD: begin
                    r_state <= ST_ERR_DIV;
                    r_iter  <= ITER_BITS'(ROOT_BITS - 1);
                end
                ST_ERR_DIV: begin
                    if (iter_done) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_iter <= r_iter - ITER_BITS'(1);
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> o_in_ready)
        else $error("input blocked while engine idle");

    a_iter_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE || r_state == ST_DONE) |-> iter_done)
        else $error("iteration count left over after a pass");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_OUT_LOAD) |-> out_free)
        else $error("result register overwritten before transfer");

    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result raised outside the done step");
`endif

endmodule

// ===== rtl/monte_carlo_mean_error_accumulator_top.sv =====
// Running mean and standard error accumulator.
//
// Input channel i_in carries one Q4.12 weight per transfer with flags first
// (clear sums, count and saturation before adding) and last (report after
// adding). Output channel o_out carries one report per last-flagged transfer:
// event count, mean = sum / count and error = isqrt(sq_sum - sum^2 / count)
// / count, all truncated, plus the sticky count-saturation flag.
//
// Throughput: a weight is added in the cycle of its transfer, one per cycle.
// A report runs on a snapshot in a shared shift/subtract engine, one bit (two
// radicand bits for the root) per cycle, through the mean division, the
// multiply, the product division, the root and the error division before
// o_out.valid rises. Weights without last keep flowing meanwhile; a transfer
// with last waits until the engine is back in idle.
//
// Reset (i_rst_n low at a clock edge) zeroes the sums, count and flag and
// drops any pending report. If the receiver stalls, the report stays in the
// output register; a finished next report holds in the engine until the
// register is taken, while weights without last are still accepted.
module monte_carlo_mean_error_accumulator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mcme_in_if.sink     i_in,
    mcme_out_if.source  o_out
);
    import mcme_pkg::*;

    t_dp_cmd cmd;
    logic    in_ready;
    logic    out_valid;

    // Sequencer: handshakes and the step order of the report engine.
    mcme_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_last   (i_in.last),
        .o_in_ready  (in_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    // Accumulators, snapshot, shared arithmetic engine and output register.
    mcme_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_weight          (i_in.weight),
        .i_first           (i_in.first),
        .o_event_count     (o_out.event_count),
        .o_mean_value      (o_out.mean_value),
        .o_error_value     (o_out.error_value),
        .o_count_saturated (o_out.count_saturated)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

endmodule
